@@ sv/rxbxf_pkg.sv @@
package rxbxf_pkg;

   // input commands
   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_LOW_LEVEL  = 2'd0;
   localparam logic [1:0] CSR_HIGH_LEVEL = 2'd1;
   localparam logic [1:0] CSR_XON_CHAR   = 2'd2;
   localparam logic [1:0] CSR_XOFF_CHAR  = 2'd3;

   localparam logic [7:0] XON_CHAR_RESET  = 8'd17;
   localparam logic [7:0] XOFF_CHAR_RESET = 8'd19;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_byte;
      logic [8:0] fill_count;
      logic       flow_send;
      logic [7:0] flow_byte;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic [8:0] low_level;
      logic [8:0] high_level;
      logic [7:0] xon_char;
      logic [7:0] xoff_char;
   } cfg_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ring_ctl_type;

endpackage

@@ sv/rxbxf_ring.sv @@
module rxbxf_ring #(
   parameter int BUFFER_DEPTH = 256,
   parameter int AW           = $clog2(BUFFER_DEPTH)
) (
   input  logic                  clock,
   input  rxbxf_pkg::ring_ctl_type ring_ctl,
   input  logic [AW-1:0]         wr_addr,
   input  logic [7:0]            wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [7:0]            rd_data
);
   import rxbxf_pkg::*;

   logic [7:0] mem_ff [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ring_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data held while the result waits downstream
   always_ff @(posedge clock) begin
      if (ring_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rxbxf_flow.sv @@
module rxbxf_flow #(
   parameter int BUFFER_DEPTH = 256,
   parameter int AW           = $clog2(BUFFER_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  rxbxf_pkg::req_type      item,
   input  rxbxf_pkg::cfg_type      cfg,
   output rxbxf_pkg::ring_ctl_type ring_ctl,
   output logic [AW-1:0]           wr_addr,
   output logic [7:0]              wr_data,
   output logic [AW-1:0]           rd_addr,
   output rxbxf_pkg::rsp_type      result
);
   import rxbxf_pkg::*;

   localparam int CW   = $clog2(BUFFER_DEPTH + 1);
   localparam int CMPW = (CW > 9) ? CW : 9;

   logic [AW-1:0] widx_ff, widx_in;
   logic [AW-1:0] ridx_ff, ridx_in;
   logic [CW-1:0] count_ff, count_in;
   logic          xon_sent_ff, xon_sent_in;
   logic          xoff_sent_ff, xoff_sent_in;
   rsp_type       result_ff, result_in;
   logic          full;

   assign full = (count_ff == CW'(BUFFER_DEPTH));

   always_comb begin
      ring_ctl     = '0;
      widx_in      = widx_ff;
      ridx_in      = ridx_ff;
      count_in     = count_ff;
      xon_sent_in  = xon_sent_ff;
      xoff_sent_in = xoff_sent_ff;
      result_in    = '0;
      if (advance) begin
         if (item.command == CMD_STORE) begin
            if (full) begin
               result_in.overflow = 1'b1;
            end else begin
               ring_ctl.wr_en = 1'b1;
               widx_in  = (widx_ff == AW'(BUFFER_DEPTH - 1)) ? '0 : widx_ff + AW'(1);
               count_in = count_ff + CW'(1);
            end
            if ((CMPW'(count_in) > CMPW'(cfg.high_level)) && !xoff_sent_ff) begin
               result_in.flow_send = 1'b1;
               result_in.flow_byte = cfg.xoff_char;
               xoff_sent_in        = 1'b1;
               xon_sent_in         = 1'b0;
            end
         end else if (count_ff != '0) begin
            ring_ctl.rd_en       = 1'b1;
            result_in.read_valid = 1'b1;
            ridx_in  = (ridx_ff == AW'(BUFFER_DEPTH - 1)) ? '0 : ridx_ff + AW'(1);
            count_in = count_ff - CW'(1);
            if ((CMPW'(count_in) < CMPW'(cfg.low_level)) && !xon_sent_ff) begin
               result_in.flow_send = 1'b1;
               result_in.flow_byte = cfg.xon_char;
               xon_sent_in         = 1'b1;
               xoff_sent_in        = 1'b0;
            end
         end
         result_in.fill_count = 9'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff      <= '0;
         ridx_ff      <= '0;
         count_ff     <= '0;
         xon_sent_ff  <= 1'b0;
         xoff_sent_ff <= 1'b0;
      end else begin
         widx_ff      <= widx_in;
         ridx_ff      <= ridx_in;
         count_ff     <= count_in;
         xon_sent_ff  <= xon_sent_in;
         xoff_sent_ff <= xoff_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign wr_addr = widx_ff;
   assign wr_data = item.rx_byte;
   assign rd_addr = ridx_ff;
   assign result  = result_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(count_ff) <= CMPW'(BUFFER_DEPTH))
      else $error("fill count above buffer depth");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(xon_sent_ff && xoff_sent_ff))
      else $error("xon and xoff both marked sent");

   a_overflow_on_full: assert property (@(posedge clock) disable iff (reset)
      (advance && item.command == CMD_STORE && full) |=> result_ff.overflow)
      else $error("store into full buffer not flagged");

   a_single_port_op: assert property (@(posedge clock) disable iff (reset)
      !(ring_ctl.wr_en && ring_ctl.rd_en))
      else $error("ring written and read for one transaction");

endmodule

@@ sv/rx_buffer_xon_xoff_flow_core.sv @@
// uart receive ring buffer with xon/xoff flow control. each request transaction either
// stores a received byte (command 0) or reads one byte out (command 1); every request
// gives exactly one response carrying the read byte, the fill count after the step, an
// optional flow control byte to transmit, and an overflow flag for a byte dropped on a
// full buffer. a read of an empty buffer returns read_valid 0 and changes nothing.
// xoff goes out once when the count climbs above high_level after a store, xon once when
// it falls below low_level after a read; sending either re-arms the other. throughput is
// one transaction per cycle while the response side does not stall; each request passes
// the input register, then the result register, with registered ring read data. no
// clearing pass: the ring needs none. configuration writes are taken at any time but
// should only be made while the block is idle.
module rx_buffer_xon_xoff_flow_core #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  rxbxf_pkg::req_type req_data,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rxbxf_pkg::rsp_type rsp_data,
   // configuration writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_wdata
);
   import rxbxf_pkg::*;

   localparam int AW       = $clog2(BUFFER_DEPTH);
   // reset levels: 70% and 90% of depth, capped to the 9-bit register
   localparam int LOW_RAW  = (70 * BUFFER_DEPTH) / 100;
   localparam int HIGH_RAW = (90 * BUFFER_DEPTH) / 100;
   localparam logic [8:0] LOW_RESET  = 9'((LOW_RAW > 511) ? 511 : LOW_RAW);
   localparam logic [8:0] HIGH_RESET = 9'((HIGH_RAW > 511) ? 511 : HIGH_RAW);

   // input register slot
   logic         in_valid_ff, in_valid_in;
   req_type      in_data_ff;
   // result register handshake
   logic         out_valid_ff, out_valid_in;
   logic         take;
   logic         advance;

   cfg_type      cfg_ff, cfg_in;

   ring_ctl_type ring_ctl;
   logic [AW-1:0] wr_addr;
   logic [7:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]   rd_data;
   rsp_type      result;

   // the slot moves into the result register whenever that register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
   end

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOW_LEVEL:  cfg_in.low_level  = csr_wdata;
            CSR_HIGH_LEVEL: cfg_in.high_level = csr_wdata;
            CSR_XON_CHAR:   cfg_in.xon_char   = csr_wdata[7:0];
            CSR_XOFF_CHAR:  cfg_in.xoff_char  = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_level  <= LOW_RESET;
         cfg_ff.high_level <= HIGH_RESET;
         cfg_ff.xon_char   <= XON_CHAR_RESET;
         cfg_ff.xoff_char  <= XOFF_CHAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pointer, count and flow flag update plus result register
   rxbxf_flow #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .AW           (AW)
   ) u_flow (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .item     (in_data_ff),
      .cfg      (cfg_ff),
      .ring_ctl (ring_ctl),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .result   (result)
   );

   // ring storage; read data lands alongside the result register
   rxbxf_ring #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .AW           (AW)
   ) u_ring (
      .clock    (clock),
      .ring_ctl (ring_ctl),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   // merge the registered read byte; zero when no byte was read
   always_comb begin
      rsp_data           = result;
      rsp_data.read_byte = result.read_valid ? rd_data : 8'd0;
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ tb/sv/rx_buffer_xon_xoff_flow_checker.sv @@
`timescale 1ns / 100ps

module rx_buffer_xon_xoff_flow_checker #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  rxbxf_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rxbxf_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_wdata,
   output int                 error_count,
   output int                 pending_count,
   output int                 response_count,
   output int                 flow_count,
   output int                 overflow_count,
   output int                 empty_read_count
);
   import rxbxf_pkg::*;

   localparam int LOW_RAW  = (70 * BUFFER_DEPTH) / 100;
   localparam int HIGH_RAW = (90 * BUFFER_DEPTH) / 100;
   localparam int LOW_RESET  = (LOW_RAW > 511) ? 511 : LOW_RAW;
   localparam int HIGH_RESET = (HIGH_RAW > 511) ? 511 : HIGH_RAW;

   // shadow of the ring buffer and its flow state
   logic [7:0]  rx_ring [BUFFER_DEPTH];
   int unsigned ring_head;
   int unsigned ring_tail;
   int unsigned ring_fill;
   bit          xon_sent;
   bit          xoff_sent;
   cfg_type     settings;

   rsp_type pending_responses [$];

   int mismatches     = 0;
   int responses_seen = 0;
   int flow_bytes     = 0;
   int dropped_bytes  = 0;
   int empty_reads    = 0;

   // one request transaction applied to the shadow buffer
   function automatic rsp_type buffer_step(req_type item);
      rsp_type r;
      r = '0;
      if (item.command == CMD_STORE) begin
         if (ring_fill >= BUFFER_DEPTH) begin
            r.overflow = 1'b1;
         end else begin
            rx_ring[ring_head] = item.rx_byte;
            ring_head = (ring_head + 1 >= BUFFER_DEPTH) ? 0 : ring_head + 1;
            ring_fill++;
         end
         // checked even when the byte was dropped
         if (ring_fill > settings.high_level && !xoff_sent) begin
            r.flow_send = 1'b1;
            r.flow_byte = settings.xoff_char;
            xoff_sent   = 1'b1;
            xon_sent    = 1'b0;
         end
      end else if (ring_fill != 0) begin
         r.read_valid = 1'b1;
         r.read_byte  = rx_ring[ring_tail];
         ring_tail = (ring_tail + 1 >= BUFFER_DEPTH) ? 0 : ring_tail + 1;
         ring_fill--;
         if (ring_fill < settings.low_level && !xon_sent) begin
            r.flow_send = 1'b1;
            r.flow_byte = settings.xon_char;
            xon_sent    = 1'b1;
            xoff_sent   = 1'b0;
         end
      end else begin
         empty_reads++;
      end
      r.fill_count = 9'(ring_fill);
      if (r.flow_send) flow_bytes++;
      if (r.overflow) dropped_bytes++;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [8:0] want,
                                input logic [8:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ring_head  = 0;
         ring_tail  = 0;
         ring_fill  = 0;
         xon_sent   = 1'b0;
         xoff_sent  = 1'b0;
         settings.low_level  = 9'(LOW_RESET);
         settings.high_level = 9'(HIGH_RESET);
         settings.xon_char   = XON_CHAR_RESET;
         settings.xoff_char  = XOFF_CHAR_RESET;
         pending_responses.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOW_LEVEL:  settings.low_level  = csr_wdata;
               CSR_HIGH_LEVEL: settings.high_level = csr_wdata;
               CSR_XON_CHAR:   settings.xon_char   = csr_wdata[7:0];
               CSR_XOFF_CHAR:  settings.xoff_char  = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) pending_responses.push_back(buffer_step(req_data));
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (pending_responses.size() == 0) begin
               $error("response transaction with none expected: %h", rsp_data);
               mismatches++;
            end else begin
               want = pending_responses.pop_front();
               compare_field("read_valid", 9'(want.read_valid), 9'(rsp_data.read_valid));
               compare_field("read_byte", 9'(want.read_byte), 9'(rsp_data.read_byte));
               compare_field("fill_count", want.fill_count, rsp_data.fill_count);
               compare_field("flow_send", 9'(want.flow_send), 9'(rsp_data.flow_send));
               compare_field("flow_byte", 9'(want.flow_byte), 9'(rsp_data.flow_byte));
               compare_field("overflow", 9'(want.overflow), 9'(rsp_data.overflow));
            end
         end
      end
      pending_count    <= pending_responses.size();
      error_count      <= mismatches;
      response_count   <= responses_seen;
      flow_count       <= flow_bytes;
      overflow_count   <= dropped_bytes;
      empty_read_count <= empty_reads;
   end

endmodule

@@ tb/sv/rx_buffer_xon_xoff_flow_core_tb.sv @@
`timescale 1ns / 100ps

module rx_buffer_xon_xoff_flow_core_tb;
   import rxbxf_pkg::*;

   localparam int BUFFER_DEPTH  = 256;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 400;   // receiver hold-off, long enough to back up the input
   localparam int SETTLE_CYCLES = 4;     // slack after the last response is back
   localparam int DRAIN_CYCLES  = 10;
   localparam int PHASE_ITEMS   = 205;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_LOW_LEVEL;
   logic [8:0] csr_wdata = '0;

   int error_count;
   int pending_count;
   int response_count;
   int flow_count;
   int overflow_count;
   int empty_read_count;

   // idle rates in percent, changed per phase by the stimulus
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_go       = 1'b0;
   int cycle_count   = 0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rx_buffer_xon_xoff_flow_core #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   rx_buffer_xon_xoff_flow_checker #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_checker (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata,
      .error_count,
      .pending_count,
      .response_count,
      .flow_count,
      .overflow_count,
      .empty_read_count
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random stalls, or one long hold-off when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            // counted here so the sender keeps offering meanwhile
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // offer one request transaction, with random idle cycles ahead of it;
   // returns at the edge where it was taken, valid left high
   task automatic offer_request(input logic cmd, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, rx_byte: data};
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and wait until every response has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // all four registers in a row; bit 8 of the char writes is random and must be masked
   task automatic program_registers(input logic [8:0] low, input logic [8:0] high,
                                    input logic [7:0] xon, input logic [7:0] xoff);
      write_register(CSR_LOW_LEVEL, low);
      write_register(CSR_HIGH_LEVEL, high);
      write_register(CSR_XON_CHAR, {1'($urandom_range(1)), xon});
      write_register(CSR_XOFF_CHAR, {1'($urandom_range(1)), xoff});
      csr_valid <= 1'b0;
   endtask

   // bursts that lean towards storing or reading in turn, so the fill count
   // swings across the thresholds; some bursts are an even mix as noise
   task automatic run_traffic(input int count);
      int burst;
      int store_pct;
      bit filling;
      filling = 1'b1;
      while (count > 0) begin
         burst = ($urandom_range(3) == 0) ? $urandom_range(40, 140) : $urandom_range(1, 24);
         if ($urandom_range(7) == 0) store_pct = 50;
         else store_pct = filling ? 85 : 15;
         filling = !filling;
         for (int n = 0; n < burst && count > 0; n++) begin
            offer_request(($urandom_range(99) < store_pct) ? CMD_STORE : CMD_READ,
                          8'($urandom_range(255)));
            count--;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset settings (low 179, high 230) ---
      // read of an empty buffer: no data, no xon
      offer_request(CMD_READ, 8'hFF);
      offer_request(CMD_STORE, 8'h00);
      offer_request(CMD_STORE, 8'hFF);
      offer_request(CMD_STORE, 8'h5A);
      // first read drops below low level: xon goes out once
      offer_request(CMD_READ, 8'h00);
      offer_request(CMD_READ, 8'hA5);
      offer_request(CMD_READ, 8'h5A);
      offer_request(CMD_READ, 8'h00);
      settle();

      // --- directed, tight thresholds and extreme flow chars ---
      program_registers(9'd2, 9'd3, 8'hFF, 8'h00);
      offer_request(CMD_STORE, 8'h01);
      offer_request(CMD_STORE, 8'h02);
      offer_request(CMD_STORE, 8'h80);
      offer_request(CMD_STORE, 8'h7F);   // count 4 above 3: xoff
      offer_request(CMD_STORE, 8'hAA);
      repeat (5) offer_request(CMD_READ, 8'($urandom_range(255)));   // xon at count 1
      offer_request(CMD_READ, 8'h00);
      settle();

      // --- random phases: two settings per idle regime ---
      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase)
            0: begin
               // one xoff at the first store that leaves a byte held, xon never
               program_registers(9'd0, 9'd0, 8'h00, 8'hFF);
               run_traffic(PHASE_ITEMS);
            end
            1: begin
               // one xon at the first valid read, xoff never
               program_registers(9'd256, 9'd256, 8'($urandom_range(255)),
                                 8'($urandom_range(255)));
               run_traffic(PHASE_ITEMS);
            end
            2: begin
               program_registers(9'd256, 9'd511, 8'($urandom_range(255)),
                                 8'($urandom_range(255)));
               // one byte in then drain past empty; the valid read sends xon
               // or finds it sent, so xoff is armed either way
               offer_request(CMD_STORE, 8'($urandom_range(255)));
               repeat (260) offer_request(CMD_READ, 8'($urandom_range(255)));
               // response side holds off while the buffer fills and overflows
               hold_go = 1'b1;
               repeat (262) offer_request(CMD_STORE, 8'($urandom_range(255)));
               settle();
               // buffer full and xoff armed: a dropped byte still sends xoff
               program_registers(9'd256, 9'd255, 8'($urandom_range(255)),
                                 8'($urandom_range(255)));
               repeat (2) offer_request(CMD_STORE, 8'($urandom_range(255)));
            end
            3: begin
               program_registers(9'd511, 9'd511, 8'($urandom_range(255)),
                                 8'($urandom_range(255)));
               run_traffic(PHASE_ITEMS);
            end
            4: begin
               // low thresholds where the random walk crosses them often
               logic [8:0] low;
               low = 9'($urandom_range(0, 64));
               program_registers(low, 9'($urandom_range(low, 96)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)));
               run_traffic(PHASE_ITEMS);
            end
            default: begin
               program_registers(9'd179, 9'd230, XON_CHAR_RESET, XOFF_CHAR_RESET);
               run_traffic(PHASE_ITEMS);
            end
         endcase
         // pause until every response is back before the next settings
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d transactions under 8 register settings and 3 idle regimes",
               response_count);
      $display("flow bytes %0d, dropped bytes %0d, reads of an empty buffer %0d",
               flow_count, overflow_count, empty_read_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
